@@ design/pngcx_pkg.sv @@
package pngcx_pkg;

   localparam int SIG_BYTES   = 8;
   localparam int FIELD_BYTES = 4;
   localparam int CNT_W       = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_SIG,
      PH_LEN,
      PH_TYPE,
      PH_DATA,
      PH_CRC,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_TRUNC     = 2'd2
   } status_type;

   typedef struct packed {
      logic        is_status;
      logic [7:0]  data_byte;
      status_type  status_code;
      logic [31:0] chunk_length;
      logic        run_last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type res;
   } qwrite_type;

endpackage

@@ design/pngcx_front.sv @@
module pngcx_front
   import pngcx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  in_byte,
   input  logic        end_of_file,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   output qwrite_type  qwrite
);

   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [31:0]        length_ff, length_in;
   logic [31:0]        type_ff, type_in;
   logic               matched_ff, matched_in;
   logic [31:0]        wanted_ff;
   logic               accept;
   logic               have_data;
   logic               found_now;
   logic               emit;
   result_type         res;

   assign accept = push && !full;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      type_in    = type_ff;
      matched_in = matched_ff;
      have_data  = 1'b0;
      found_now  = 1'b0;
      unique case (phase_ff)
         PH_SIG: begin
            if (count_ff == CNT_W'(SIG_BYTES - 1)) begin
               phase_in = PH_LEN;
               count_in = '0;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         PH_LEN: begin
            length_in = {length_ff[23:0], in_byte};
            if (count_ff == CNT_W'(FIELD_BYTES - 1)) begin
               phase_in = PH_TYPE;
               count_in = '0;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         PH_TYPE: begin
            type_in = {type_ff[23:0], in_byte};
            if (count_ff == CNT_W'(FIELD_BYTES - 1)) begin
               matched_in = (type_in == wanted_ff);
               if (length_ff == 32'd0) begin
                  phase_in = PH_CRC;
                  count_in = '0;
               end else begin
                  phase_in = PH_DATA;
                  count_in = length_ff;
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         PH_DATA: begin
            have_data = matched_ff;
            count_in  = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               phase_in = PH_CRC;
            end
         end
         PH_CRC: begin
            if (count_ff == CNT_W'(FIELD_BYTES - 1)) begin
               count_in = '0;
               if (matched_ff) begin
                  phase_in  = PH_DONE;
                  found_now = 1'b1;
               end else begin
                  phase_in = PH_LEN;
               end
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      res.is_status    = 1'b1;
      res.data_byte    = '0;
      res.status_code  = ST_FOUND;
      res.chunk_length = '0;
      res.run_last     = 1'b1;
      emit             = 1'b0;
      if (found_now) begin
         emit             = 1'b1;
         res.chunk_length = length_in;
      end else if (end_of_file) begin
         emit = (phase_ff != PH_DONE);
         if (matched_in && (phase_in == PH_DATA || phase_in == PH_CRC)) begin
            res.status_code  = ST_TRUNC;
            res.chunk_length = length_in;
         end else begin
            res.status_code = ST_NOT_FOUND;
         end
      end else if (have_data) begin
         emit          = 1'b1;
         res.is_status = 1'b0;
         res.data_byte = in_byte;
         res.run_last  = 1'b0;
      end

      // end of file returns the parser to its reset state
      if (end_of_file) begin
         phase_in   = PH_SIG;
         count_in   = '0;
         length_in  = '0;
         type_in    = '0;
         matched_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SIG;
         count_ff   <= '0;
         length_ff  <= '0;
         type_ff    <= '0;
         matched_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         length_ff  <= length_in;
         type_ff    <= type_in;
         matched_ff <= matched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff <= '0;
      end else if (csr_write_enable) begin
         wanted_ff <= csr_write_data;
      end
   end

   assign qwrite.valid = accept && emit;
   assign qwrite.res   = res;

endmodule

@@ design/pngcx_queue.sv @@
module pngcx_queue
   import pngcx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  qwrite_type qwrite,
   output logic       full,
   output logic       empty,
   input  logic       pop,
   output result_type head
);

   result_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = qwrite.valid;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= qwrite.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (!do_push && do_pop) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      do_push |-> !full)
      else $error("item written into full queue");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue count did not advance");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (!do_push && do_pop) |=> count_ff == $past(count_ff) - QCNT_W'(1))
      else $error("queue count did not drop");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff != QCNT_W'(QUEUE_DEPTH)) |->
         (wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])
      else $error("queue pointers disagree with count");
`endif

endmodule

@@ design/png_chunk_extract_by_type_unit.sv @@
// A result is registered into the result queue and shown on the rsp_ ports from its head.
// Throughput: one byte per cycle while full is low; the parser keeps one state step per byte.
// full rises only when the 4-entry result queue holds 4 items not yet popped.
// Reset (synchronous, active high) returns the parser to the signature phase,
// empties the result queue and clears the wanted type to zero.
module png_chunk_extract_by_type_unit
   import pngcx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_file,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_is_status,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_status_code,
   output logic [31:0] rsp_chunk_length,
   output logic        rsp_run_last,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   qwrite_type qwrite;
   result_type head;

   pngcx_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .in_byte          (req_in_byte),
      .end_of_file      (req_end_of_file),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .qwrite           (qwrite)
   );

   pngcx_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .qwrite (qwrite),
      .full   (full),
      .empty  (empty),
      .pop    (pop),
      .head   (head)
   );

   assign rsp_is_status    = head.is_status;
   assign rsp_data_byte    = head.data_byte;
   assign rsp_status_code  = head.status_code;
   assign rsp_chunk_length = head.chunk_length;
   assign rsp_run_last     = head.run_last;

endmodule

@@ verif/png_chunk_checker.sv @@
`timescale 1ns / 100ps

module png_chunk_checker
   import pngcx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_file,
   input  logic        empty,
   input  logic        pop,
   input  logic        rsp_is_status,
   input  logic [7:0]  rsp_data_byte,
   input  logic [1:0]  rsp_status_code,
   input  logic [31:0] rsp_chunk_length,
   input  logic        rsp_run_last,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   output int          err_count,
   output int          pending,
   output int          n_payload,
   output int          n_found,
   output int          n_missing,
   output int          n_trunc
);

   logic [31:0] match_type;
   phase_type   walk_phase;
   logic [31:0] walk_count;
   logic [31:0] len_acc;
   logic [31:0] type_acc;
   logic        hit;
   result_type  chunk_expect_q[$];

   task automatic clear_walk();
      walk_phase = PH_SIG;
      walk_count = '0;
      len_acc    = '0;
      type_acc   = '0;
      hit        = 1'b0;
   endtask

   function automatic result_type status_item(status_type code, logic [31:0] len);
      result_type r;
      r = '{is_status: 1'b1, data_byte: 8'h00, status_code: code,
            chunk_length: len, run_last: 1'b1};
      return r;
   endfunction

   task automatic step_parser(input logic [7:0] b, input logic last);
      logic       was_done;
      logic       data_out;
      logic       found_now;
      result_type r;
      was_done  = (walk_phase == PH_DONE);
      data_out  = 1'b0;
      found_now = 1'b0;
      case (walk_phase)
         PH_SIG: begin
            walk_count = walk_count + 1;
            if (walk_count >= SIG_BYTES) begin
               walk_phase = PH_LEN;
               walk_count = '0;
            end
         end
         PH_LEN: begin
            len_acc    = {len_acc[23:0], b};
            walk_count = walk_count + 1;
            if (walk_count >= FIELD_BYTES) begin
               walk_phase = PH_TYPE;
               walk_count = '0;
            end
         end
         PH_TYPE: begin
            type_acc   = {type_acc[23:0], b};
            walk_count = walk_count + 1;
            if (walk_count >= FIELD_BYTES) begin
               hit = (type_acc == match_type);
               if (len_acc == '0) begin
                  walk_phase = PH_CRC;
                  walk_count = '0;
               end else begin
                  walk_phase = PH_DATA;
                  walk_count = len_acc;
               end
            end
         end
         PH_DATA: begin
            data_out   = hit;
            walk_count = walk_count - 1;
            if (walk_count == '0)
               walk_phase = PH_CRC;
         end
         PH_CRC: begin
            walk_count = walk_count + 1;
            if (walk_count >= FIELD_BYTES) begin
               walk_count = '0;
               if (hit) begin
                  walk_phase = PH_DONE;
                  found_now  = 1'b1;
               end else begin
                  walk_phase = PH_LEN;
               end
            end
         end
         default: ;
      endcase

      if (found_now) begin
         chunk_expect_q.push_back(status_item(ST_FOUND, len_acc));
         if (last)
            clear_walk();
      end else if (last) begin
         if (!was_done) begin
            if (hit && (walk_phase == PH_DATA || walk_phase == PH_CRC))
               chunk_expect_q.push_back(status_item(ST_TRUNC, len_acc));
            else
               chunk_expect_q.push_back(status_item(ST_NOT_FOUND, 32'h0));
         end
         clear_walk();
      end else if (data_out) begin
         r = '{is_status: 1'b0, data_byte: b, status_code: ST_FOUND,
               chunk_length: 32'h0, run_last: 1'b0};
         chunk_expect_q.push_back(r);
      end
   endtask

   task automatic check_item();
      result_type want;
      if (chunk_expect_q.size() == 0) begin
         err_count++;
         if (err_count <= 10)
            $display("%0t: unexpected item: status=%0b byte=%02h code=%0d len=%08h last=%0b",
                     $time, rsp_is_status, rsp_data_byte, rsp_status_code,
                     rsp_chunk_length, rsp_run_last);
         return;
      end
      want = chunk_expect_q.pop_front();
      if (rsp_is_status !== want.is_status || rsp_data_byte !== want.data_byte ||
          rsp_status_code !== want.status_code ||
          rsp_chunk_length !== want.chunk_length || rsp_run_last !== want.run_last) begin
         err_count++;
         if (err_count <= 10) begin
            $display("%0t: mismatch, expected status=%0b byte=%02h code=%0d len=%08h last=%0b",
                     $time, want.is_status, want.data_byte, want.status_code,
                     want.chunk_length, want.run_last);
            $display("%0t:           actual status=%0b byte=%02h code=%0d len=%08h last=%0b",
                     $time, rsp_is_status, rsp_data_byte, rsp_status_code,
                     rsp_chunk_length, rsp_run_last);
         end
      end
      if (!want.is_status)
         n_payload++;
      else if (want.status_code == ST_FOUND)
         n_found++;
      else if (want.status_code == ST_TRUNC)
         n_trunc++;
      else
         n_missing++;
   endtask

   initial begin
      err_count  = 0;
      pending    = 0;
      n_payload  = 0;
      n_found    = 0;
      n_missing  = 0;
      n_trunc    = 0;
      match_type = '0;
      clear_walk();
   end

   always @(posedge clock) begin
      if (reset) begin
         chunk_expect_q.delete();
         match_type = '0;
         clear_walk();
         pending <= 0;
      end else begin
         if (pop && !empty)
            check_item();
         if (push && !full)
            step_parser(req_in_byte, req_end_of_file);
         if (csr_write_enable)
            match_type = csr_write_data;
         pending <= chunk_expect_q.size();
      end
   end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import pngcx_pkg::*;

   localparam int          CYCLE_LIMIT = 200000;
   localparam int          ITEM_TARGET = 1150;
   localparam logic [31:0] TYPE_IDAT   = 32'h49444154;
   localparam logic [31:0] TYPE_IHDR   = 32'h49484452;
   localparam logic [31:0] TYPE_ONES   = 32'hFFFFFFFF;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_in_byte;
   logic        req_end_of_file;
   logic        empty;
   logic        pop;
   logic        rsp_is_status;
   logic [7:0]  rsp_data_byte;
   logic [1:0]  rsp_status_code;
   logic [31:0] rsp_chunk_length;
   logic        rsp_run_last;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   int err_count, pending, n_payload, n_found, n_missing, n_trunc;
   int cycles;
   int idle_pct;
   int hold_cycles;
   int bytes_sent;
   int files_sent;
   int type_settings;
   logic [31:0] wanted_now;
   logic [7:0]  file_bytes[$];
   int          cut_marks[$];

   png_chunk_extract_by_type_unit uut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .req_end_of_file  (req_end_of_file),
      .empty            (empty),
      .pop              (pop),
      .rsp_is_status    (rsp_is_status),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_status_code  (rsp_status_code),
      .rsp_chunk_length (rsp_chunk_length),
      .rsp_run_last     (rsp_run_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   png_chunk_checker chk (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_in_byte      (req_in_byte),
      .req_end_of_file  (req_end_of_file),
      .empty            (empty),
      .pop              (pop),
      .rsp_is_status    (rsp_is_status),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_status_code  (rsp_status_code),
      .rsp_chunk_length (rsp_chunk_length),
      .rsp_run_last     (rsp_run_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .err_count        (err_count),
      .pending          (pending),
      .n_payload        (n_payload),
      .n_found          (n_found),
      .n_missing        (n_missing),
      .n_trunc          (n_trunc)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side; a requested hold-off is timed here
   initial begin
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            pop <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         pop <= !reset && ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push            <= 1'b1;
      req_in_byte     <= b;
      req_end_of_file <= last;
      @(posedge clock);
      while (full)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_file(input int cut);
      for (int i = 0; i < cut; i++)
         send_byte(file_bytes[i], i == cut - 1);
      files_sent++;
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_wanted(input logic [31:0] v);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      wanted_now = v;
      type_settings++;
   endtask

   task automatic add_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--)
         file_bytes.push_back(w[8*i +: 8]);
   endtask

   task automatic start_file();
      file_bytes.delete();
      cut_marks.delete();
      repeat (SIG_BYTES) file_bytes.push_back(8'($urandom));
   endtask

   task automatic add_chunk(input logic [31:0] len, input logic [31:0] typ);
      add_word(len);
      add_word(typ);
      cut_marks.push_back(file_bytes.size());
      repeat (len) file_bytes.push_back(8'($urandom));
      repeat (FIELD_BYTES) file_bytes.push_back(8'($urandom));
      cut_marks.push_back(file_bytes.size());
   endtask

   task automatic build_random_file();
      int          pick;
      logic [31:0] len;
      logic [31:0] typ;
      start_file();
      if ($urandom_range(11) == 0) begin
         // garbage stream, mostly ends inside the header fields
         repeat ($urandom_range(12)) file_bytes.push_back(8'($urandom));
         return;
      end
      repeat ($urandom_range(1, 3)) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(4);
         pick = $urandom_range(9);
         if (pick < 4)
            typ = wanted_now;
         else if (pick < 6)
            typ = wanted_now ^ (32'h1 << $urandom_range(31));
         else
            typ = $urandom;
         add_chunk(len, typ);
      end
      repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom));
   endtask

   function automatic int pick_cut();
      int pick;
      pick = $urandom_range(9);
      if (pick >= 8 && cut_marks.size() > 0)
         return cut_marks[$urandom_range(cut_marks.size() - 1)];
      else if (pick >= 6)
         return $urandom_range(1, file_bytes.size());
      return file_bytes.size();
   endfunction

   initial begin
      logic [31:0] next_type;
      reset            = 1'b1;
      push             = 1'b0;
      req_in_byte      = 8'h00;
      req_end_of_file  = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = 32'h0;
      idle_pct         = 31;
      hold_cycles      = 0;
      cycles           = 0;
      bytes_sent       = 0;
      files_sent       = 0;
      type_settings    = 1;
      wanted_now       = 32'h0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero-length chunk matching the reset type, file ends on its last CRC byte
      start_file();
      add_chunk(32'h0, 32'h0);
      send_file(file_bytes.size());
      // one-byte file
      file_bytes.delete();
      file_bytes.push_back(8'hFF);
      send_file(1);
      // all-ones type and length, cut inside the data
      write_wanted(TYPE_ONES);
      start_file();
      add_word(TYPE_ONES);
      add_word(TYPE_ONES);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hA5);
      send_file(file_bytes.size());

      while (bytes_sent < ITEM_TARGET) begin
         if (files_sent % 6 == 0) begin
            case ($urandom_range(4))
               0: next_type = 32'h0;
               1: next_type = TYPE_IDAT;
               2: next_type = TYPE_IHDR;
               3: next_type = TYPE_ONES;
               default: next_type = $urandom;
            endcase
            write_wanted(next_type);
         end
         if (files_sent == 12) begin
            // long result stall while a long matching chunk streams in
            idle_pct    = 0;
            hold_cycles = 150;
            start_file();
            add_chunk(32'd30, wanted_now);
            send_file(file_bytes.size());
            idle_pct = 31;
         end else begin
            if (files_sent >= 18 && files_sent < 23)
               idle_pct = 0;
            else
               idle_pct = 31;
            build_random_file();
            if (file_bytes.size() > 0)
               send_file(pick_cut());
         end
      end

      idle_pct = 31;
      wait_idle();
      repeat (10) @(posedge clock);
      $display("%0d bytes in %0d files under %0d type settings, incl. result stall",
               bytes_sent, files_sent, type_settings);
      $display("checked %0d payload bytes, %0d found, %0d not found, %0d truncated",
               n_payload, n_found, n_missing, n_trunc);
      if (err_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
